[rtl/dtmf_pkg.sv]
// shared types, constants and table function of the dtmf tone generator
package dtmf_pkg;

	// fixed field widths
	localparam int unsigned AMP_W      = 14;
	localparam int unsigned TONE_W     = 20;
	localparam int unsigned FADE_W     = 19;
	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned SAMPLE_W   = 16;
	localparam int unsigned FREQ_W     = 11;
	localparam int unsigned APB_ADDR_W = 4;
	localparam int unsigned APB_DATA_W = 32;

	// default parameter values
	localparam int unsigned DEF_SAMPLE_RATE  = 8000;
	localparam int unsigned DEF_SINE_ENTRIES = 1024;
	localparam int unsigned DEF_PHASE_BITS   = 32;

	// register reset values
	localparam logic [AMP_W-1:0]  AMP_RESET  = AMP_W'(8000);
	localparam logic [TONE_W-1:0] TONE_RESET = TONE_W'(1600);
	localparam logic [FADE_W-1:0] FADE_RESET = FADE_W'(160);

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_AMPLITUDE    = 2'd0;
	localparam logic [1:0] REG_TONE_SAMPLES = 2'd1;
	localparam logic [1:0] REG_FADE_SAMPLES = 2'd2;

	// operation codes
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_START = 1'b1;

	// keypad row and column frequencies in hz
	localparam logic [FREQ_W-1:0] LOW_FREQS [4] = '{
		FREQ_W'(697), FREQ_W'(770), FREQ_W'(852), FREQ_W'(941)
	};
	localparam logic [FREQ_W-1:0] HIGH_FREQS [4] = '{
		FREQ_W'(1209), FREQ_W'(1336), FREQ_W'(1477), FREQ_W'(1633)
	};

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIDX,
		ST_HIDX,
		ST_ENVMUL,
		ST_ENVSEL,
		ST_DIV,
		ST_SMPMUL,
		ST_FIN
	} state_t;

	// envelope branch
	typedef enum logic [1:0] {
		ENV_ZERO,
		ENV_DIV,
		ENV_FULL
	} env_mode_t;

	// fixed-point sine of a turn fraction in q32, rounded to q15
	function automatic logic signed [SAMPLE_W-1:0] sine_entry(logic [63:0] fq);
		logic        neg;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		neg = (fq >= 64'h8000_0000);
		r = fq & 64'h7FFF_FFFF;
		if (r > 64'h4000_0000) begin
			r = 64'h8000_0000 - r;
		end
		x  = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		t  = 64'h4000_0000 - x2 / 64'd110;
		t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd72;
		t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd42;
		t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd20;
		t  = 64'h4000_0000 - ((x2 * t) >> 30) / 64'd6;
		s  = (x * t) >> 30;
		v  = (s * 64'd32768 + 64'h2000_0000) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return neg ? -$signed(SAMPLE_W'(v)) : $signed(SAMPLE_W'(v));
	endfunction

endpackage

[rtl/dtmf_if.sv]
// item channels of the dtmf tone generator
interface dtmf_in_if;
	import dtmf_pkg::*;
	logic               valid;
	logic               ready;
	logic               operation;
	logic [DIGIT_W-1:0] digit;
	modport source (output valid, operation, digit, input ready);
	modport sink (input valid, operation, digit, output ready);
endinterface

interface dtmf_out_if;
	import dtmf_pkg::*;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       active;
	logic                       last_sample;
	modport source (output valid, sample, active, last_sample, input ready);
	modport sink (input valid, sample, active, last_sample, output ready);
endinterface

[rtl/dtmf_tone_generator_with_fade_unit.sv]
// dtmf dual-tone generator with linear fade: sequencer, shared multiplier, registers
// a tick while idle goes from idle straight to fin; a tone sample steps through lidx, hidx,
// envmul, envsel, div (inside a fade only), smpmul and fin, using the
// shared multiplier (four uses per sample) and the 14-step envelope divider.
// one item at a time: a new item is taken only in idle, and fin waits for output space.
// reset: asynchronous, tone idle, phases and count zero, registers at their defaults.
module dtmf_tone_generator_with_fade_unit #(
	parameter int unsigned SAMPLE_RATE  = dtmf_pkg::DEF_SAMPLE_RATE,
	parameter int unsigned SINE_ENTRIES = dtmf_pkg::DEF_SINE_ENTRIES,
	parameter int unsigned PHASE_BITS   = dtmf_pkg::DEF_PHASE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [dtmf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [dtmf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [dtmf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	dtmf_in_if.sink                             tone_in,
	dtmf_out_if.source                          tone_out
);
	import dtmf_pkg::*;

	localparam int unsigned IdxW  = $clog2(SINE_ENTRIES);
	localparam int unsigned EntW  = IdxW + 1;
	localparam int unsigned MulAW = (PHASE_BITS > TONE_W) ? PHASE_BITS : TONE_W;
	localparam int unsigned MulBW = (EntW > SAMPLE_W) ? EntW : SAMPLE_W;
	localparam int unsigned ProdW = MulAW + MulBW;
	localparam logic [EntW-1:0] ENTRIES_C = EntW'(SINE_ENTRIES);
	localparam logic [IdxW-1:0] IDX_MAX   = IdxW'(SINE_ENTRIES - 1);

	// phase step of a frequency, rounded half up
	function automatic logic [PHASE_BITS-1:0] step_for(logic [FREQ_W-1:0] f);
		logic [63:0] num;
		num = (64'(f) << PHASE_BITS) + 64'(SAMPLE_RATE / 2);
		return PHASE_BITS'(num / 64'(SAMPLE_RATE));
	endfunction

	localparam logic [PHASE_BITS-1:0] LOW_STEPS [4] = '{
		step_for(LOW_FREQS[0]), step_for(LOW_FREQS[1]),
		step_for(LOW_FREQS[2]), step_for(LOW_FREQS[3])
	};
	localparam logic [PHASE_BITS-1:0] HIGH_STEPS [4] = '{
		step_for(HIGH_FREQS[0]), step_for(HIGH_FREQS[1]),
		step_for(HIGH_FREQS[2]), step_for(HIGH_FREQS[3])
	};

	// configuration registers
	logic [AMP_W-1:0]  amp_q;
	logic [TONE_W-1:0] tone_q;
	logic [FADE_W-1:0] fade_q;

	// tone state
	state_t                 state_q;
	state_t                 state_d;
	logic                   tone_active_q;
	logic [TONE_W-1:0]      count_q;
	logic [PHASE_BITS-1:0]  low_phase_q;
	logic [PHASE_BITS-1:0]  high_phase_q;
	logic [PHASE_BITS-1:0]  low_step_q;
	logic [PHASE_BITS-1:0]  high_step_q;

	// datapath
	logic [MulAW-1:0]           mul_a;
	logic [MulBW-1:0]           mul_b;
	logic [ProdW-1:0]           mul_q;
	env_mode_t                  env_mode_q;
	env_mode_t                  env_mode_d;
	logic [TONE_W-1:0]          env_sel;
	logic [AMP_W-1:0]           env_q;
	logic signed [SAMPLE_W-1:0] slow_q;
	logic signed [SAMPLE_W-1:0] shigh_q;
	logic                       neg_q;
	logic signed [SAMPLE_W:0]   sum;
	logic signed [SAMPLE_W:0]   sum_abs;
	logic [SAMPLE_W-1:0]        mag;
	logic [EntW-1:0]            idx_raw;
	logic [IdxW-1:0]            rom_addr;
	logic signed [SAMPLE_W-1:0] rom_q;
	logic [TONE_W-1:0]          n_eff;
	logic [TONE_W-1:0]          fade_ext;
	logic                       last;
	logic [SAMPLE_W-2:0]        q15;
	logic signed [SAMPLE_W-1:0] sample_d;
	logic                       div_start;
	logic                       div_done;
	logic [AMP_W-1:0]           div_quot;
	logic                       in_fire;
	logic                       fin_go;

	// output register
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;
	logic                       out_active_q;
	logic                       out_last_q;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q  <= AMP_RESET;
			tone_q <= TONE_RESET;
			fade_q <= FADE_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_AMPLITUDE:    amp_q  <= pwdata[AMP_W-1:0];
				REG_TONE_SAMPLES: tone_q <= pwdata[TONE_W-1:0];
				REG_FADE_SAMPLES: fade_q <= pwdata[FADE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_AMPLITUDE:    prdata = APB_DATA_W'(amp_q);
			REG_TONE_SAMPLES: prdata = APB_DATA_W'(tone_q);
			REG_FADE_SAMPLES: prdata = APB_DATA_W'(fade_q);
			default:          prdata = '0;
		endcase
	end

	// envelope branch from count, length and fade
	always_comb begin
		n_eff    = (tone_q == '0) ? TONE_W'(1) : tone_q;
		fade_ext = TONE_W'(fade_q);
		env_sel  = count_q;
		if (count_q >= n_eff) begin
			env_mode_d = ENV_ZERO;
		end else if (count_q < fade_ext) begin
			env_mode_d = ENV_DIV;
		end else if (({1'b0, count_q} + {1'b0, fade_ext}) > {1'b0, n_eff}) begin
			env_mode_d = ENV_DIV;
			env_sel    = n_eff - count_q;
		end else begin
			env_mode_d = ENV_FULL;
		end
		last = (({1'b0, count_q} + 1'b1) >= {1'b0, n_eff});
	end

	// table index from the phase product
	always_comb begin
		idx_raw  = mul_q[PHASE_BITS +: EntW];
		rom_addr = (idx_raw >= ENTRIES_C) ? IDX_MAX : idx_raw[IdxW-1:0];
	end

	dtmf_sine_rom #(
		.SINE_ENTRIES(SINE_ENTRIES)
	) u_rom (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (rom_q)
	);

	dtmf_env_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (mul_q[AMP_W+TONE_W-1:0]),
		.den    (fade_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// sine sum magnitude and the signed output sample
	always_comb begin
		sum     = SAMPLE_W'(0) + $signed({slow_q[SAMPLE_W-1], slow_q})
		          + $signed({shigh_q[SAMPLE_W-1], shigh_q});
		sum_abs = sum[SAMPLE_W] ? -sum : sum;
		mag     = sum_abs[SAMPLE_W-1:0];
		q15     = mul_q[15 +: SAMPLE_W-1];
		sample_d = neg_q ? -$signed({1'b0, q15}) : $signed({1'b0, q15});
	end

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			ST_LIDX: begin
				mul_a = MulAW'(low_phase_q);
				mul_b = MulBW'(ENTRIES_C);
			end
			ST_HIDX: begin
				mul_a = MulAW'(high_phase_q);
				mul_b = MulBW'(ENTRIES_C);
			end
			ST_ENVMUL: begin
				mul_a = MulAW'(env_sel);
				mul_b = MulBW'(amp_q);
			end
			ST_SMPMUL: begin
				mul_a = MulAW'(env_q);
				mul_b = MulBW'(mag);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// sequencer next state
	always_comb begin
		state_d   = state_q;
		in_fire   = 1'b0;
		div_start = 1'b0;
		fin_go    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (tone_in.valid) begin
					in_fire = 1'b1;
					if (tone_in.operation == OP_START || tone_active_q) begin
						state_d = ST_LIDX;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_LIDX:   state_d = ST_HIDX;
			ST_HIDX:   state_d = ST_ENVMUL;
			ST_ENVMUL: state_d = ST_ENVSEL;
			ST_ENVSEL: begin
				if (env_mode_q == ENV_DIV) begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end else begin
					state_d = ST_SMPMUL;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_SMPMUL;
				end
			end
			ST_SMPMUL: state_d = ST_FIN;
			ST_FIN: begin
				if (!out_valid_q || tone_out.ready) begin
					fin_go  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign tone_in.ready = (state_q == ST_IDLE);

	// state register and tone state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			tone_active_q <= 1'b0;
			count_q       <= '0;
			low_phase_q   <= '0;
			high_phase_q  <= '0;
			low_step_q    <= '0;
			high_step_q   <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && tone_in.operation == OP_START) begin
				low_step_q    <= LOW_STEPS[tone_in.digit[3:2]];
				high_step_q   <= HIGH_STEPS[tone_in.digit[1:0]];
				low_phase_q   <= '0;
				high_phase_q  <= '0;
				count_q       <= '0;
				tone_active_q <= 1'b1;
			end
			if (fin_go && tone_active_q) begin
				low_phase_q  <= low_phase_q + low_step_q;
				high_phase_q <= high_phase_q + high_step_q;
				count_q      <= count_q + 1'b1;
				if (last) begin
					tone_active_q <= 1'b0;
				end
			end
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (tone_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LIDX, ST_HIDX: mul_q <= ProdW'(mul_a * mul_b);
			ST_ENVMUL: begin
				mul_q      <= ProdW'(mul_a * mul_b);
				slow_q     <= rom_q;
				env_mode_q <= env_mode_d;
			end
			ST_ENVSEL: begin
				shigh_q <= rom_q;
				env_q   <= (env_mode_q == ENV_FULL) ? amp_q : '0;
			end
			ST_DIV: begin
				if (div_done) begin
					env_q <= div_quot;
				end
			end
			ST_SMPMUL: begin
				mul_q <= ProdW'(mul_a * mul_b);
				neg_q <= sum[SAMPLE_W];
			end
			default: ;
		endcase
		if (fin_go) begin
			out_sample_q <= tone_active_q ? sample_d : '0;
			out_active_q <= tone_active_q;
			out_last_q   <= tone_active_q && last;
		end
	end

	assign tone_out.valid       = out_valid_q;
	assign tone_out.sample      = out_sample_q;
	assign tone_out.active      = out_active_q;
	assign tone_out.last_sample = out_last_q;

endmodule

[rtl/dtmf_sine_rom.sv]
// sine table rom with registered read
module dtmf_sine_rom #(
	parameter int unsigned SINE_ENTRIES = dtmf_pkg::DEF_SINE_ENTRIES,
	localparam int unsigned IdxW = $clog2(SINE_ENTRIES)
) (
	input  logic                                clk,
	input  logic [IdxW-1:0]                     addr,
	output logic signed [dtmf_pkg::SAMPLE_W-1:0] data_q
);
	import dtmf_pkg::*;

	typedef logic signed [SAMPLE_W-1:0] rom_t [SINE_ENTRIES];

	// table built at elaboration from the fixed-point sine
	function automatic rom_t build_rom();
		rom_t        tab;
		logic [63:0] fq;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			fq = (64'(k) << 32) / 64'(SINE_ENTRIES);
			tab[k] = sine_entry(fq);
		end
		return tab;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	// registered read port
	always_ff @(posedge clk) begin
		data_q <= SINE_ROM[addr];
	end

endmodule

[rtl/dtmf_env_div.sv]
// restoring divider for the fade envelope, one quotient bit per cycle
module dtmf_env_div (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  logic [dtmf_pkg::AMP_W+dtmf_pkg::TONE_W-1:0] num,
	input  logic [dtmf_pkg::FADE_W-1:0]                 den,
	output logic                                        done,
	output logic [dtmf_pkg::AMP_W-1:0]                  quot
);
	import dtmf_pkg::*;

	localparam int unsigned CntW = $clog2(AMP_W);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [FADE_W-1:0] rem_q;
	logic [AMP_W-1:0]  bits_q;
	logic [FADE_W:0]   rem_shift;
	logic              ge;
	logic [FADE_W:0]   rem_sub;

	// one trial subtraction
	always_comb begin
		rem_shift = {rem_q, bits_q[AMP_W-1]};
		ge        = (rem_shift >= {1'b0, den});
		rem_sub   = rem_shift - {1'b0, den};
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(AMP_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// remainder and quotient shift register; upper numerator part is below den
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= FADE_W'(num >> AMP_W);
			bits_q <= num[AMP_W-1:0];
		end else if (busy_q) begin
			rem_q  <= ge ? rem_sub[FADE_W-1:0] : rem_shift[FADE_W-1:0];
			bits_q <= {bits_q[AMP_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = bits_q;

endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
// self-checking bench for the dtmf tone generator with fade envelope
module tb;
	import dtmf_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned SETTLE_CYCLES = 30;
	localparam int unsigned TABLE_SHIFT   = DEF_PHASE_BITS - $clog2(DEF_SINE_ENTRIES);
	localparam logic [63:0] Q30_UNITY     = 64'h4000_0000;
	localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
	localparam int unsigned PHASE_ITEMS   = 210;
	localparam int unsigned START_PCT     = 12;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       active;
		logic                       last_sample;
	} tone_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	dtmf_in_if  tone_in();
	dtmf_out_if tone_out();

	dtmf_tone_generator_with_fade_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.tone_in  (tone_in),
		.tone_out (tone_out)
	);

	// predicted tone state and register copies
	logic signed [SAMPLE_W-1:0]   sine_q15 [DEF_SINE_ENTRIES];
	logic [DEF_PHASE_BITS-1:0]    low_acc;
	logic [DEF_PHASE_BITS-1:0]    high_acc;
	logic [DEF_PHASE_BITS-1:0]    low_inc;
	logic [DEF_PHASE_BITS-1:0]    high_inc;
	logic [TONE_W-1:0]            sample_index;
	logic                         tone_on;
	logic [AMP_W-1:0]             amp_setting;
	logic [TONE_W-1:0]            length_setting;
	logic [FADE_W-1:0]            fade_setting;

	tone_result_t pending_samples [$];
	tone_result_t want_sample;

	int send_idle_pct;
	int recv_stall_pct;
	int mismatches;
	int items_sent;
	int samples_checked;
	int tones_finished;
	int settings_used;
	int cycle_count;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("dtmf_tone_generator_with_fade_unit: mismatch");
			$finish;
		end
	end

	// q15 sine of table entry k: taylor series in q30, folded to the first quarter turn
	function automatic logic signed [SAMPLE_W-1:0] quarter_wave_sine(int unsigned k);
		logic [63:0] turn;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		int unsigned divisors [4];
		divisors = '{72, 42, 20, 6};
		turn = (64'(k) << 32) / 64'(DEF_SINE_ENTRIES);
		r = {33'd0, turn[30:0]};
		if (r > Q30_UNITY) begin
			r = 64'h8000_0000 - r;
		end
		x  = (r * HALF_PI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t  = Q30_UNITY - x2 / 64'd110;
		foreach (divisors[j]) begin
			t = Q30_UNITY - ((x2 * t) >> 30) / 64'(divisors[j]);
		end
		s = (x * t) >> 30;
		v = (s * 64'd32768 + 64'h2000_0000) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return turn[31] ? -$signed(v[SAMPLE_W-1:0]) : $signed(v[SAMPLE_W-1:0]);
	endfunction

	// phase increment per sample, ties rounded up
	function automatic logic [DEF_PHASE_BITS-1:0] phase_step(logic [FREQ_W-1:0] freq);
		logic [63:0] num;
		num = (64'(freq) << DEF_PHASE_BITS) + 64'(DEF_SAMPLE_RATE / 2);
		return DEF_PHASE_BITS'(num / 64'(DEF_SAMPLE_RATE));
	endfunction

	// next output sample for one accepted item; advances the predicted tone
	function automatic tone_result_t predict_tone_sample(logic op, logic [DIGIT_W-1:0] key);
		tone_result_t res;
		logic [63:0]  n;
		logic [63:0]  i;
		logic [63:0]  fade;
		logic [63:0]  amp;
		logic [63:0]  env;
		logic [63:0]  mag;
		logic [63:0]  q;
		longint       sum;
		res = '0;
		if (op == OP_START) begin
			low_inc      = phase_step(LOW_FREQS[key[3:2]]);
			high_inc     = phase_step(HIGH_FREQS[key[1:0]]);
			low_acc      = '0;
			high_acc     = '0;
			sample_index = '0;
			tone_on      = 1'b1;
		end
		if (!tone_on) begin
			return res;
		end
		n    = (length_setting == '0) ? 64'd1 : 64'(length_setting);
		i    = 64'(sample_index);
		fade = 64'(fade_setting);
		amp  = 64'(amp_setting);
		// envelope: past the end, rising ramp first, then falling ramp, else flat
		if (i >= n) begin
			env = '0;
		end else if (i < fade) begin
			env = (i * amp) / fade;
		end else if (i + fade > n) begin
			env = ((n - i) * amp) / fade;
		end else begin
			env = amp;
		end
		sum = longint'(sine_q15[low_acc >> TABLE_SHIFT]) +
			longint'(sine_q15[high_acc >> TABLE_SHIFT]);
		mag = 64'(sum < 0 ? -sum : sum);
		q   = (env * mag) >> 15;
		res.sample      = SAMPLE_W'(sum < 0 ? -longint'(q) : longint'(q));
		res.active      = 1'b1;
		res.last_sample = (i + 64'd1 >= n);
		low_acc      = low_acc + low_inc;
		high_acc     = high_acc + high_inc;
		sample_index = TONE_W'(i + 64'd1);
		if (res.last_sample) begin
			tone_on = 1'b0;
		end
		return res;
	endfunction

	task automatic note_mismatch(string what);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s", what);
		end
	endtask

	// output side: compare each accepted sample, then pick the next ready
	always @(posedge clk) begin
		if (arst_n && tone_out.valid && tone_out.ready) begin
			samples_checked++;
			if (pending_samples.size() == 0) begin
				note_mismatch($sformatf("unexpected item: sample %0d active %0b last %0b",
					tone_out.sample, tone_out.active, tone_out.last_sample));
			end else begin
				want_sample = pending_samples.pop_front();
				if (tone_out.sample !== want_sample.sample ||
					tone_out.active !== want_sample.active ||
					tone_out.last_sample !== want_sample.last_sample) begin
					note_mismatch($sformatf(
						"item %0d: expected %0d/%0b/%0b got %0d/%0b/%0b",
						samples_checked, want_sample.sample, want_sample.active,
						want_sample.last_sample, tone_out.sample, tone_out.active,
						tone_out.last_sample));
				end else if (want_sample.last_sample) begin
					tones_finished++;
				end
			end
		end
		tone_out.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// offer one item after a random idle gap and wait for it to be taken
	task automatic send_item(logic op, logic [DIGIT_W-1:0] key);
		while ($urandom_range(99) < send_idle_pct) begin
			tone_in.valid <= 1'b0;
			@(posedge clk);
		end
		tone_in.valid     <= 1'b1;
		tone_in.operation <= op;
		tone_in.digit     <= key;
		do begin
			@(posedge clk);
		end while (!tone_in.ready);
		pending_samples.push_back(predict_tone_sample(op, key));
		items_sent++;
	endtask

	// stop offering, drain every expected item, then let the block settle
	task automatic wait_tone_quiet();
		tone_in.valid <= 1'b0;
		while (pending_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic register_check(logic [1:0] idx);
		logic [31:0] want;
		logic [31:0] got;
		case (idx)
			REG_AMPLITUDE:    want = 32'(amp_setting);
			REG_TONE_SAMPLES: want = 32'(length_setting);
			REG_FADE_SAMPLES: want = 32'(fade_setting);
			default:          want = '0;
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		got = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (got !== want) begin
			note_mismatch($sformatf("register %0d: expected %0d read %0d", idx, want, got));
		end
	endtask

	task automatic config_write(logic [1:0] idx, logic [31:0] value);
		wait_tone_quiet();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(posedge clk);
		end while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_AMPLITUDE:    amp_setting    = AMP_W'(value);
			REG_TONE_SAMPLES: length_setting = TONE_W'(value);
			REG_FADE_SAMPLES: fade_setting   = FADE_W'(value);
			default: ;
		endcase
		@(posedge clk);
		register_check(idx);
	endtask

	task automatic apply_setting(int unsigned amp, int unsigned len, int unsigned fade);
		config_write(REG_AMPLITUDE, 32'(amp));
		config_write(REG_TONE_SAMPLES, 32'(len));
		config_write(REG_FADE_SAMPLES, 32'(fade));
		settings_used++;
	endtask

	// reset values, then all-ones writes to see the field masks
	task automatic test_register_access();
		register_check(REG_AMPLITUDE);
		register_check(REG_TONE_SAMPLES);
		register_check(REG_FADE_SAMPLES);
		config_write(REG_AMPLITUDE, 32'hFFFF_FFFF);
		config_write(REG_TONE_SAMPLES, 32'hFFFF_FFFF);
		config_write(REG_FADE_SAMPLES, 32'hFFFF_FFFF);
	endtask

	task automatic test_idle_ticks();
		send_item(OP_TICK, 4'd0);
		send_item(OP_TICK, 4'd15);
	endtask

	// zero length tone, and a fade longer than half the tone
	task automatic test_short_tones();
		apply_setting(16383, 0, 0);
		send_item(OP_START, 4'd0);
		send_item(OP_TICK, 4'd5);
		apply_setting(12000, 4, 3);
		send_item(OP_START, 4'd15);
		repeat (4) send_item(OP_TICK, 4'd0);
	endtask

	task automatic test_restart_mid_tone();
		apply_setting(9000, 6, 2);
		send_item(OP_START, 4'd5);
		send_item(OP_TICK, 4'd3);
		send_item(OP_START, 4'd10);
		send_item(OP_TICK, 4'd7);
		send_item(OP_TICK, 4'd12);
	endtask

	// amplitude to zero mid-tone, then length cut below the running count
	task automatic test_register_change_mid_tone();
		apply_setting(16383, 10, 0);
		send_item(OP_START, 4'd9);
		repeat (2) send_item(OP_TICK, 4'd1);
		config_write(REG_AMPLITUDE, 32'd0);
		send_item(OP_TICK, 4'd2);
		config_write(REG_TONE_SAMPLES, 32'd3);
		send_item(OP_TICK, 4'd6);
		send_item(OP_TICK, 4'd8);
	endtask

	// rotate through register settings, extremes included
	task automatic pick_setting();
		int unsigned len;
		len = $urandom_range(2, 48);
		case (settings_used % 6)
			0: apply_setting(16383, $urandom_range(1, 40), 0);
			1: apply_setting(0, $urandom_range(1, 40), $urandom_range(0, 20));
			2: apply_setting($urandom_range(0, 16383), 1048575, 524287);
			3: apply_setting($urandom_range(0, 16383), $urandom_range(0, 2),
				$urandom_range(0, 524287));
			default: apply_setting($urandom_range(0, 16383), len, $urandom_range(0, len));
		endcase
	endtask

	task automatic random_phase(int idle_pct, int stall_pct);
		wait_tone_quiet();
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (3) begin
			pick_setting();
			repeat (PHASE_ITEMS / 3) begin
				send_item(($urandom_range(99) < START_PCT) ? OP_START : OP_TICK,
					DIGIT_W'($urandom_range(15)));
			end
		end
	endtask

	// tones of random digits under each pacing mix
	task automatic test_random_traffic();
		random_phase(0, 0);
		random_phase(74, 0);
		random_phase(0, 74);
		random_phase(29, 29);
	endtask

	// stimulus sequence
	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		tone_in.valid     = 1'b0;
		tone_in.operation = OP_TICK;
		tone_in.digit     = '0;
		tone_out.ready    = 1'b0;
		send_idle_pct     = 0;
		recv_stall_pct    = 0;
		mismatches        = 0;
		items_sent        = 0;
		samples_checked   = 0;
		tones_finished    = 0;
		settings_used     = 0;
		cycle_count       = 0;
		amp_setting       = AMP_RESET;
		length_setting    = TONE_RESET;
		fade_setting      = FADE_RESET;
		low_acc           = '0;
		high_acc          = '0;
		low_inc           = '0;
		high_inc          = '0;
		sample_index      = '0;
		tone_on           = 1'b0;
		for (int k = 0; k < DEF_SINE_ENTRIES; k++) begin
			sine_q15[k] = quarter_wave_sine(k);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_register_access();
		test_idle_ticks();
		test_short_tones();
		test_restart_mid_tone();
		test_register_change_mid_tone();
		test_random_traffic();
		wait_tone_quiet();

		$display("ran %0d items, checked %0d samples, %0d tones played to their end",
			items_sent, samples_checked, tones_finished);
		$display("%0d register settings under four pacing mixes, %0d mismatches",
			settings_used, mismatches);
		if (mismatches == 0) begin
			$display("dtmf_tone_generator_with_fade_unit: match");
		end else begin
			$display("dtmf_tone_generator_with_fade_unit: mismatch");
		end
		$finish;
	end

endmodule
